>>> hdl/fixed_slot_pool_allocator_defines.svh
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator_defines.svh
// Assertion macros for the slot pool allocator. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef FIXED_SLOT_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define FSPA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fspa: assertion failed");
// checked at every edge, reset included
`define FSPA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fspa: assertion failed");
`else
`define FSPA_ASSERT(lbl, clk, rstn, prop)
`define FSPA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> hdl/fspa_pkg.sv
// ----------------------------------------------------------------------------
// fspa_pkg
// Shared widths, codes and types of the slot pool allocator.
// ----------------------------------------------------------------------------
package fspa_pkg;

  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int ALIGN_W    = 13;
  localparam int COUNT_W    = 9;
  localparam int INDEX_W    = 8;
  localparam int STRIDE_W   = 17;
  localparam int SPAN_W     = 34;
  localparam int CFG_IDX_W  = 2;
  localparam int OUT_DATA_W = 72;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = 5;

  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic [STRIDE_W-1:0] stride;
    logic [SPAN_W-1:0]   span;
  } geom_t;

endpackage

>>> hdl/fixed_slot_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator
// Pool of equal slots handed out and taken back through a LIFO free list.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. An allocate pops the free-list head
// from the link memory in ST_MUL, then ST_FIN registers its result (an
// allocate on an empty list goes straight to ST_FIN); a free inside the
// pool first waits in ST_DIV while the 32-step restoring divider maps the
// address offset to a slot, then does the link write and, in ST_MUL, the
// slot-address multiply; a free outside the pool goes straight to ST_FIN.
// ST_FIN waits for a free output register. The next request is taken in
// the cycle after a result is registered, even while that result still
// waits on out_tready. After reset and after every configuration write the
// link memory is rebuilt by a sweep during which no request is accepted.
// Frees of an already free slot are not detected.
// ----------------------------------------------------------------------------
`include "fixed_slot_pool_allocator_defines.svh"

module fixed_slot_pool_allocator
  import fspa_pkg::*;
#(
  parameter int SLOTS        = 256,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]     cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [ADDR_W-1:0]     in_tdata,   // [31:0] free_address
  input  logic                  in_tuser,   // [0] op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] slot_index, [39:8] slot_address, [56:40] stride_bytes,
  // [65:57] live_count, [66] pool_empty, [71:67] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser   // [0] ok
);

  localparam int NW = $clog2(SLOTS + 1);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = IW + STRIDE_W;
  localparam logic [NW-1:0] NIL = NW'(SLOTS);
  localparam logic [ADDR_W-1:0] AMASK =
    (ADDRESS_BITS >= ADDR_W) ? '1 : ADDR_W'((64'(1) << ADDRESS_BITS) - 64'(1));

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   base_r;
  logic [SIZE_W-1:0]   osize_r;
  logic [ALIGN_W-1:0]  oalign_r;
  logic [COUNT_W-1:0]  scount_r;
  logic [NW-1:0]       head_r, head_nxt;
  logic [NW-1:0]       count_r, count_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                ok_r, ok_nxt;
  logic                op_r;
  logic [PW-1:0]       prod_r;
  logic [PW-1:0]       prod_w;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                out_ok_r;
  logic                load_out;

  logic [NW-1:0]       n_slots;
  geom_t               geom;
  logic                clr_busy;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [NW-1:0]       mem_rdata;
  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic [ADDR_W-1:0]   div_quot;
  logic [ADDR_W:0]     off_w;
  logic                in_range;
  logic                head_ok;
  logic                accept;
  logic [ADDR_W-1:0]   slot_addr_w;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      osize_r  <= SIZE_W'(4);
      oalign_r <= ALIGN_W'(4);
      scount_r <= COUNT_W'(256);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BASE:  base_r   <= cfg_wdata;
        REG_SIZE:  osize_r  <= cfg_wdata[SIZE_W-1:0];
        REG_ALIGN: oalign_r <= cfg_wdata[ALIGN_W-1:0];
        REG_COUNT: scount_r <= cfg_wdata[COUNT_W-1:0];
      endcase
    end
  end

  assign n_slots = (32'(scount_r) > 32'(SLOTS)) ? NIL : NW'(scount_r);

  fspa_geom #(.SLOTS(SLOTS)) u_geom (
    .clk       (clk),
    .obj_size  (osize_r),
    .obj_align (oalign_r),
    .n_slots   (n_slots),
    .geom      (geom)
  );

  fspa_link_store #(.SLOTS(SLOTS)) u_links (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_wr_en),
    .n_slots (n_slots),
    .busy    (clr_busy),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (head_r),
    .raddr   (head_r[IW-1:0]),
    .rdata   (mem_rdata)
  );

  fspa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (off_w[ADDR_W-1:0]),
    .divisor  (geom.stride),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign off_w    = {1'b0, in_tdata} - {1'b0, base_r};
  assign in_range = !off_w[ADDR_W] && ({2'b00, off_w[ADDR_W-1:0]} < geom.span);
  assign head_ok  = head_r < NIL;
  assign accept   = in_tvalid && in_tready;
  assign prod_w   = PW'(idx_r) * PW'(geom.stride);
  assign mem_waddr = div_quot[IW-1:0];

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    ok_nxt    = ok_r;
    mem_we    = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == OP_ALLOC) begin
            ok_nxt    = head_ok;
            idx_nxt   = head_ok ? head_r[IW-1:0] : '0;
            state_nxt = head_ok ? ST_MUL : ST_FIN;
          end else begin
            ok_nxt    = 1'b0;
            idx_nxt   = '0;
            div_start = in_range;
            state_nxt = in_range ? ST_DIV : ST_FIN;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ok_nxt    = 1'b1;
          idx_nxt   = div_quot[IW-1:0];
          mem_we    = 1'b1;
          head_nxt  = NW'(div_quot[IW-1:0]);
          if (count_r != '0) begin
            count_nxt = count_r - NW'(1);
          end
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (op_r == OP_ALLOC) begin
          head_nxt = mem_rdata;
          if (count_r < NIL) begin
            count_nxt = count_r + NW'(1);
          end
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (clr_busy) begin
      head_nxt  = (n_slots == '0) ? NIL : '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign slot_addr_w = ok_r ? ((base_r + ADDR_W'(prod_r)) & AMASK) : '0;

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    ok_r  <= ok_nxt;
    if (accept) begin
      op_r <= in_tuser;
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod_w;
    end
    if (load_out) begin
      out_ok_r   <= ok_r;
      out_data_r <= {5'b0, !head_ok, COUNT_W'(count_r), geom.stride,
                     slot_addr_w, INDEX_W'(idx_r)};
    end
  end

  assign in_tready  = (state_r == ST_IDLE) && !clr_busy;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;

  `FSPA_ASSERT(a_head_range, clk, rst_n, head_r <= NIL)
  `FSPA_ASSERT(a_count_range, clk, rst_n, count_r <= NIL)
  `FSPA_ASSERT(a_div_alive, clk, rst_n, (state_r == ST_DIV) |-> (div_busy || div_done))
  `FSPA_ASSERT(a_out_no_overwrite, clk, rst_n, load_out |-> (!out_valid_r || out_tready))
  `FSPA_ASSERT_ALWAYS(a_rst_rebuild, clk, !rst_n |=> (!out_tvalid && clr_busy))

endmodule

>>> hdl/fspa_geom.sv
// ----------------------------------------------------------------------------
// fspa_geom
// Slot stride from object size and alignment, and pool span in bytes.
// ----------------------------------------------------------------------------
module fspa_geom
  import fspa_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic                         clk,
  input  logic [SIZE_W-1:0]            obj_size,
  input  logic [ALIGN_W-1:0]           obj_align,
  input  logic [$clog2(SLOTS+1)-1:0]   n_slots,
  output geom_t                        geom
);

  localparam int NW = $clog2(SLOTS + 1);

  logic [ALIGN_W:0]       align_w;
  logic [STRIDE_W-1:0]    size_w;
  logic [STRIDE_W-1:0]    amask_w;
  logic [STRIDE_W-1:0]    stride_w;
  logic [NW+STRIDE_W-1:0] span_w;
  logic [STRIDE_W-1:0]    stride_r;
  logic [SPAN_W-1:0]      span_r;

  always_comb begin
    align_w = (ALIGN_W+1)'(4);
    for (int k = 2; k < ALIGN_W; k++) begin
      if (obj_align > ALIGN_W'(1 << k)) begin
        align_w = (ALIGN_W+1)'(1) << (k + 1);
      end
    end
  end

  assign size_w   = (obj_size == '0) ? STRIDE_W'(1) : STRIDE_W'(obj_size);
  assign amask_w  = STRIDE_W'(align_w) - STRIDE_W'(1);
  assign stride_w = (size_w + amask_w) & ~amask_w;
  assign span_w   = (NW+STRIDE_W)'(n_slots) * (NW+STRIDE_W)'(stride_r);

  always_ff @(posedge clk) begin
    stride_r <= stride_w;
    span_r   <= SPAN_W'(span_w);
  end

  assign geom.stride = stride_r;
  assign geom.span   = span_r;

endmodule

>>> hdl/fspa_div.sv
// ----------------------------------------------------------------------------
// fspa_div
// Restoring divider, one quotient bit per cycle: offset / stride.
// ----------------------------------------------------------------------------
module fspa_div
  import fspa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [ADDR_W-1:0]   dividend,
  input  logic [STRIDE_W-1:0] divisor,
  output logic                busy,
  output logic                done,
  output logic [ADDR_W-1:0]   quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [STRIDE_W-1:0]  rem_r;
  logic [ADDR_W-1:0]    dq_r;
  logic [STRIDE_W-1:0]  dvs_r;
  logic [STRIDE_W:0]    rem_sh;
  logic [STRIDE_W:0]    rem_dif;
  logic                 q_bit;

  assign rem_sh  = {rem_r, dq_r[ADDR_W-1]};
  assign q_bit   = rem_sh >= {1'b0, dvs_r};
  assign rem_dif = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= q_bit ? rem_dif[STRIDE_W-1:0] : rem_sh[STRIDE_W-1:0];
      dq_r  <= {dq_r[ADDR_W-2:0], q_bit};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dq_r;

endmodule

>>> hdl/fspa_link_store.sv
// ----------------------------------------------------------------------------
// fspa_link_store
// Free-list link memory with its rebuild sweep (i links to i+1, last to NIL).
// ----------------------------------------------------------------------------
module fspa_link_store
  import fspa_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   restart,
  input  logic [$clog2(SLOTS+1)-1:0]             n_slots,
  output logic                                   busy,
  input  logic                                   we,
  input  logic [((SLOTS>1)?$clog2(SLOTS):1)-1:0] waddr,
  input  logic [$clog2(SLOTS+1)-1:0]             wdata,
  input  logic [((SLOTS>1)?$clog2(SLOTS):1)-1:0] raddr,
  output logic [$clog2(SLOTS+1)-1:0]             rdata
);

  localparam int NW  = $clog2(SLOTS + 1);
  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW  = $clog2(SLOTS + 2);
  localparam int CW1 = CW + 1;
  localparam logic [NW-1:0] NIL = NW'(SLOTS);

  logic [NW-1:0]  mem [SLOTS];
  logic [NW-1:0]  rdata_r;
  logic           busy_r;
  logic [CW-1:0]  cnt_r;
  logic [CW1-1:0] succ_w;
  logic [NW-1:0]  clr_val;
  logic           clr_wr;

  assign succ_w  = CW1'(cnt_r) + CW1'(1);
  assign clr_val = (succ_w < CW1'(n_slots)) ? NW'(succ_w) : NIL;
  assign clr_wr  = busy_r && (cnt_r < CW'(SLOTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (restart) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CW'(1);
      if (cnt_r == CW'(SLOTS + 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_wr) begin
      mem[cnt_r[IW-1:0]] <= clr_val;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign busy  = busy_r;
  assign rdata = rdata_r;

endmodule

>>> dv/fixed_slot_pool_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator_tb
// Self-checking bench for the slot pool allocator. A directed table covers
// reset state, pool exhaustion, empty and saturated pools, out-of-range and
// mid-slot frees, zero size, odd and maximal alignment and address wrap.
// Random phases then reprogram the pool and run allocate/free traffic with
// random stalls on both streams, checked against a free-list mirror.
// ----------------------------------------------------------------------------
module fixed_slot_pool_allocator_tb;
  import fspa_pkg::*;

  localparam int unsigned POOL_SLOTS  = 256;
  localparam int unsigned NIL_SLOT    = POOL_SLOTS;
  localparam int          STALL_LIMIT = 4000;
  localparam int          PHASES      = 12;
  localparam int          PHASE_ITEMS = 150;

  typedef struct packed {
    logic                ok;
    logic [INDEX_W-1:0]  slot_index;
    logic [ADDR_W-1:0]   slot_address;
    logic [STRIDE_W-1:0] stride_bytes;
    logic [COUNT_W-1:0]  live_count;
    logic                pool_empty;
  } pool_result_t;

  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic                 op;
    logic [CFG_IDX_W-1:0] sel;
    logic [ADDR_W-1:0]    value;
    bit                   checked;
    pool_result_t         want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [ADDR_W-1:0]     cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [ADDR_W-1:0]     in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  // register mirror and free-list mirror
  bit [ADDR_W-1:0]  cfg_base;
  bit [SIZE_W-1:0]  cfg_size;
  bit [ALIGN_W-1:0] cfg_align;
  bit [COUNT_W-1:0] cfg_count;
  int unsigned      link_mem [POOL_SLOTS];
  int unsigned      head_slot;
  int unsigned      live_slots;
  int unsigned      slot_stride;
  int unsigned      pool_len;

  pool_result_t pending_results [$];
  int           err_cnt;
  int           quiet_cycles;
  bit           steady;

  fixed_slot_pool_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] free_address
    .in_tuser   (in_tuser),   // [0] op
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // [7:0] slot_index, [39:8] slot_address, [56:40] stride_bytes,
    // [65:57] live_count, [66] pool_empty, [71:67] zero
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)   // [0] ok
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void relink_pool();
    int unsigned unit;
    int unsigned sz;
    int unsigned i;
    unit = 4;
    while (unit < cfg_align) unit = unit << 1;
    sz = (cfg_size == 0) ? 1 : cfg_size;
    slot_stride = ((sz + unit - 1) / unit) * unit;
    pool_len = (cfg_count > POOL_SLOTS) ? POOL_SLOTS : cfg_count;
    for (i = 0; i < POOL_SLOTS; i++) link_mem[i] = (i + 1 < pool_len) ? i + 1 : NIL_SLOT;
    head_slot = (pool_len == 0) ? NIL_SLOT : 0;
    live_slots = 0;
  endfunction

  function automatic bit [ADDR_W-1:0] slot_addr(int unsigned idx);
    return cfg_base + ADDR_W'(idx * slot_stride);
  endfunction

  function automatic pool_result_t serve_request(logic op, bit [ADDR_W-1:0] addr);
    pool_result_t     r;
    longint unsigned  span;
    int unsigned      idx;
    r = '0;
    if (op == OP_ALLOC) begin
      if (head_slot < POOL_SLOTS) begin
        idx = head_slot;
        r.ok = 1'b1;
        r.slot_index = idx[INDEX_W-1:0];
        r.slot_address = slot_addr(idx);
        head_slot = link_mem[idx];
        if (live_slots < POOL_SLOTS) live_slots++;
      end
    end else begin
      span = longint'(pool_len) * slot_stride;
      if (addr >= cfg_base && longint'(addr - cfg_base) < span) begin
        idx = (addr - cfg_base) / slot_stride;
        r.ok = 1'b1;
        r.slot_index = idx[INDEX_W-1:0];
        r.slot_address = slot_addr(idx);
        link_mem[idx] = head_slot;
        head_slot = idx;
        if (live_slots > 0) live_slots--;
      end
    end
    r.stride_bytes = slot_stride[STRIDE_W-1:0];
    r.live_count = live_slots[COUNT_W-1:0];
    r.pool_empty = (head_slot >= POOL_SLOTS);
    return r;
  endfunction

  function automatic plan_row_t row_req(logic op, bit [ADDR_W-1:0] addr);
    return '{ROW_REQ, op, REG_BASE, addr, 1'b0, '0};
  endfunction

  function automatic plan_row_t row_cfg(logic [CFG_IDX_W-1:0] sel, bit [ADDR_W-1:0] value);
    return '{ROW_CFG, OP_ALLOC, sel, value, 1'b0, '0};
  endfunction

  function automatic plan_row_t row_want(logic op, bit [ADDR_W-1:0] addr, bit ok,
                                         int unsigned idx, bit [ADDR_W-1:0] slot_a,
                                         int unsigned stride, int unsigned live, bit empty);
    pool_result_t w;
    w = '{ok, idx[INDEX_W-1:0], slot_a, stride[STRIDE_W-1:0], live[COUNT_W-1:0], empty};
    return '{ROW_REQ, op, REG_BASE, addr, 1'b1, w};
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned seen);
    if (want != seen) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      err_cnt++;
    end
  endfunction

  task automatic issue(input logic op, input bit [ADDR_W-1:0] addr, input bit checked,
                       input pool_result_t want, output pool_result_t got);
    if (!steady && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 30);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    got = serve_request(op, addr);
    pending_results.push_back(checked ? want : got);
  endtask

  task automatic program_register(input logic [CFG_IDX_W-1:0] sel,
                                  input bit [ADDR_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (sel)
      REG_BASE:  cfg_base  = value;
      REG_SIZE:  cfg_size  = value[SIZE_W-1:0];
      REG_ALIGN: cfg_align = value[ALIGN_W-1:0];
      default:   cfg_count = value[COUNT_W-1:0];
    endcase
    relink_pool();
    @(posedge clk);
  endtask

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= steady || ($urandom_range(0, 99) >= 30);
    end
  end

  always @(posedge clk) begin : result_monitor
    pool_result_t seen;
    pool_result_t want;
    seen = '{out_tuser, out_tdata[7:0], out_tdata[39:8], out_tdata[56:40],
             out_tdata[65:57], out_tdata[66]};
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending");
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("ok", want.ok, seen.ok);
        check_field("slot_index", want.slot_index, seen.slot_index);
        check_field("slot_address", want.slot_address, seen.slot_address);
        check_field("stride_bytes", want.stride_bytes, seen.stride_bytes);
        check_field("live_count", want.live_count, seen.live_count);
        check_field("pool_empty", want.pool_empty, seen.pool_empty);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("fixed_slot_pool_allocator_tb: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    plan_row_t       plan [$];
    pool_result_t    got;
    int unsigned     held_slots [$];
    int              ph;
    int              k;
    int unsigned     roll;
    int unsigned     bias;
    int unsigned     j;
    int unsigned     idx;
    bit [ADDR_W-1:0] addr;
    bit [ADDR_W-1:0] b;
    bit [ADDR_W-1:0] sz;
    bit [ADDR_W-1:0] al;
    bit [ADDR_W-1:0] cnt;

    err_cnt      = 0;
    quiet_cycles = 0;
    steady       = 1'b0;
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_BASE;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_ALLOC;
    cfg_base  = 0;
    cfg_size  = 4;
    cfg_align = 4;
    cfg_count = 256;
    relink_pool();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    plan = '{
      row_want(OP_ALLOC, 32'h0,        1, 0,   32'h0,        4, 1, 0),
      row_want(OP_ALLOC, 32'h0,        1, 1,   32'h4,        4, 2, 0),
      row_want(OP_FREE,  32'hFFFFFFFF, 0, 0,   32'h0,        4, 2, 0),
      row_want(OP_FREE,  32'd5,        1, 1,   32'h4,        4, 1, 0),
      row_want(OP_FREE,  32'd1023,     1, 255, 32'd1020,     4, 0, 0),
      row_want(OP_FREE,  32'd1024,     0, 0,   32'h0,        4, 0, 0),
      row_req(OP_ALLOC, 32'hFFFFFFFF),
      row_cfg(REG_COUNT, 32'd1),
      row_want(OP_ALLOC, 32'h0,        1, 0,   32'h0,        4, 1, 1),
      row_want(OP_ALLOC, 32'h0,        0, 0,   32'h0,        4, 1, 1),
      row_want(OP_FREE,  32'd3,        1, 0,   32'h0,        4, 0, 0),
      row_cfg(REG_COUNT, 32'd0),
      row_want(OP_ALLOC, 32'h0,        0, 0,   32'h0,        4, 0, 1),
      row_want(OP_FREE,  32'h0,        0, 0,   32'h0,        4, 0, 1),
      row_cfg(REG_COUNT, 32'd511),
      row_cfg(REG_BASE,  32'hFFFF0000),
      row_cfg(REG_SIZE,  32'd65535),
      row_cfg(REG_ALIGN, 32'd8191),
      row_want(OP_ALLOC, 32'h0,        1, 0,   32'hFFFF0000, 65536, 1, 0),
      row_want(OP_ALLOC, 32'h0,        1, 1,   32'h0,        65536, 2, 0),
      row_want(OP_FREE,  32'hFFFEFFFF, 0, 0,   32'h0,        65536, 2, 0),
      row_want(OP_FREE,  32'hFFFFFFFF, 1, 0,   32'hFFFF0000, 65536, 1, 0),
      row_req(OP_ALLOC, 32'h0),
      row_cfg(REG_SIZE,  32'd0),
      row_cfg(REG_ALIGN, 32'd0),
      row_want(OP_ALLOC, 32'h0,        1, 0,   32'hFFFF0000, 4, 1, 0),
      row_want(OP_FREE,  32'hFFFF03FF, 1, 255, 32'hFFFF03FC, 4, 0, 0),
      row_want(OP_FREE,  32'hFFFF0400, 0, 0,   32'h0,        4, 0, 0),
      row_cfg(REG_ALIGN, 32'd5),
      row_want(OP_ALLOC, 32'h0,        1, 0,   32'hFFFF0000, 8, 1, 0),
      row_cfg(REG_ALIGN, 32'd4096),
      row_cfg(REG_SIZE,  32'd1),
      row_want(OP_ALLOC, 32'h0,        1, 0,   32'hFFFF0000, 4096, 1, 0),
      row_req(OP_ALLOC, 32'h0)
    };
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) program_register(plan[i].sel, plan[i].value);
      else issue(plan[i].op, plan[i].value, plan[i].checked, plan[i].want, got);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          b = 32'h0; sz = 32'd1; al = 32'd1; cnt = 32'd256;
        end
        1: begin
          b = 32'hFFFFFFFF; sz = 32'd65535; al = 32'd4096; cnt = 32'd1;
        end
        default: begin
          case ($urandom_range(0, 2))
            0: b = 32'h0;
            1: b = $urandom();
            default: b = 32'hFFFFFFFF - $urandom_range(0, 32'h000FFFFF);
          endcase
          sz = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 65535);
          al = $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 12))
                                    : $urandom_range(0, 8191);
          roll = $urandom_range(0, 9);
          if (roll < 6)      cnt = $urandom_range(1, 12);
          else if (roll < 8) cnt = $urandom_range(13, 256);
          else if (roll < 9) cnt = $urandom_range(257, 511);
          else               cnt = 32'd0;
        end
      endcase
      program_register(REG_BASE, b);
      program_register(REG_SIZE, sz);
      program_register(REG_ALIGN, al);
      program_register(REG_COUNT, cnt);
      held_slots.delete();
      steady = (ph == 5);
      bias = $urandom_range(45, 75);

      for (k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // stray free: anywhere, just below the pool, or just past its end
          case ($urandom_range(0, 2))
            0: addr = $urandom();
            1: addr = cfg_base - 1;
            default: addr = cfg_base + ADDR_W'(pool_len * slot_stride);
          endcase
          issue(OP_FREE, addr, 1'b0, '0, got);
        end else if (roll < 12 && pool_len != 0) begin
          // free of any slot, often one already free
          addr = slot_addr($urandom_range(0, pool_len - 1));
          issue(OP_FREE, addr, 1'b0, '0, got);
        end else if (held_slots.size() == 0 || roll < bias) begin
          issue(OP_ALLOC, $urandom(), 1'b0, '0, got);
          if (got.ok) held_slots.push_back(got.slot_index);
        end else begin
          j = $urandom_range(0, held_slots.size() - 1);
          idx = held_slots[j];
          held_slots.delete(j);
          addr = slot_addr(idx) + $urandom_range(0, slot_stride - 1);
          issue(OP_FREE, addr, 1'b0, '0, got);
        end
      end
    end

    steady = 1'b0;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (err_cnt == 0) begin
      $display("fixed_slot_pool_allocator_tb: clean");
    end else begin
      $display("fixed_slot_pool_allocator_tb: errors");
    end
    $finish;
  end

endmodule
